[hdl/pru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and codes for the priority ready queue and mutex unit.
// ----------------------------------------------------------------------------
package pru_pkg;

  // operation codes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_WAIT    = 2'd2;
  localparam logic [1:0] OP_SIGNAL  = 2'd3;

  // result status codes
  localparam logic [3:0] ST_ENQUEUED     = 4'd0;
  localparam logic [3:0] ST_READY_FULL   = 4'd1;
  localparam logic [3:0] ST_DEQUEUED     = 4'd2;
  localparam logic [3:0] ST_READY_EMPTY  = 4'd3;
  localparam logic [3:0] ST_ACQUIRED     = 4'd4;
  localparam logic [3:0] ST_BLOCKED      = 4'd5;
  localparam logic [3:0] ST_WAIT_FULL    = 4'd6;
  localparam logic [3:0] ST_RELEASED     = 4'd7;
  localparam logic [3:0] ST_WOKE_WAITER  = 4'd8;
  localparam logic [3:0] ST_INVALID_LOCK = 4'd9;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] task_id;
    logic [1:0] prio_level;
    logic [1:0] lock_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] out_task;
    logic [7:0] lock_owner;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic fetch;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/pru_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/pru_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_ctrl
// Sequencer: accept, execute, optional memory fetch, result load.
// ----------------------------------------------------------------------------
module pru_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pru_pkg::dp_stat_t stat,
  output pru_pkg::ctl_cmd_t      cmd
);

  pru_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pru_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pru_pkg::S_IDLE:  if (in_valid) state_next = pru_pkg::S_EXEC;
      pru_pkg::S_EXEC:  state_next = stat.needs_read ? pru_pkg::S_FETCH : pru_pkg::S_OUT;
      pru_pkg::S_FETCH: state_next = pru_pkg::S_OUT;
      pru_pkg::S_OUT:   if (stat.out_free) state_next = pru_pkg::S_IDLE;
      default:          state_next = pru_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      pru_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      pru_pkg::S_EXEC:  cmd.exec = 1'b1;
      pru_pkg::S_FETCH: cmd.fetch = 1'b1;
      pru_pkg::S_OUT:   cmd.load_out = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/pru_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_datapath
// Ready FIFO and wait FIFO pointers, mutex state, FIFO memories and the
// result register.
// ----------------------------------------------------------------------------
module pru_datapath #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LOCKS   = 3,
  parameter int ID_BITS     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pru_pkg::in_item_t  in_data,
  input  wire pru_pkg::ctl_cmd_t  cmd,
  output pru_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pru_pkg::out_item_t      out_data
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int RA_W   = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int WA_W   = $clog2(NUM_LOCKS * QUEUE_DEPTH);
  localparam int WE_W   = LVL_W + ID_BITS;

  function automatic logic [PTR_W-1:0] fifo_tail(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  pru_pkg::in_item_t cur;

  logic [PTR_W-1:0]   ready_head  [LEVELS];
  logic [CNT_W-1:0]   ready_count [LEVELS];
  logic [PTR_W-1:0]   wait_head   [NUM_LOCKS];
  logic [CNT_W-1:0]   wait_count  [NUM_LOCKS];
  logic               lock_taken  [NUM_LOCKS];
  logic [ID_BITS-1:0] owner_store [NUM_LOCKS];

  logic [3:0] res_status;
  logic [7:0] res_task;
  logic [7:0] res_owner;

  logic [ID_BITS-1:0] id;
  logic [LVL_W-1:0]   lvl;
  logic               lk_ok;
  logic [LOCK_W-1:0]  lk;
  logic               deq_hit;
  logic [LVL_W-1:0]   deq_lvl;
  logic               wait_full;
  logic               has_waiter;

  logic [WE_W-1:0]    wait_rdata;
  logic [ID_BITS-1:0] ready_rdata;
  logic [ID_BITS-1:0] wid;
  logic [LVL_W-1:0]   push_lvl;
  logic               push_ok;
  logic               push_we;

  logic [RA_W-1:0] ready_waddr, ready_raddr;
  logic [WA_W-1:0] wait_waddr, wait_raddr;
  logic            wait_we;

  always_comb begin
    id    = ID_BITS'(cur.task_id);
    lvl   = (32'(cur.prio_level) >= 32'(LEVELS)) ? LVL_W'(LEVELS - 1) : LVL_W'(cur.prio_level);
    lk_ok = 32'(cur.lock_id) < 32'(NUM_LOCKS);
    lk    = lk_ok ? LOCK_W'(cur.lock_id) : '0;
  end

  // lowest-numbered non-empty level
  always_comb begin
    deq_hit = 1'b0;
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ready_count[i] != '0) begin
        deq_hit = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  assign wait_full  = wait_count[lk] >= CNT_W'(QUEUE_DEPTH);
  assign has_waiter = wait_count[lk] != '0;

  assign wid = wait_rdata[ID_BITS-1:0];

  // ready push: enqueue in execute, handoff of a woken waiter in fetch
  assign push_lvl = cmd.fetch ? wait_rdata[ID_BITS +: LVL_W] : lvl;
  assign push_ok  = ready_count[push_lvl] < CNT_W'(QUEUE_DEPTH);
  assign push_we  = push_ok && ((cmd.exec && cur.opcode == pru_pkg::OP_ENQUEUE) ||
                                (cmd.fetch && cur.opcode == pru_pkg::OP_SIGNAL));

  assign ready_waddr = RA_W'(32'(push_lvl) * QUEUE_DEPTH +
                             32'(fifo_tail(ready_head[push_lvl], ready_count[push_lvl])));
  assign ready_raddr = RA_W'(32'(deq_lvl) * QUEUE_DEPTH + 32'(ready_head[deq_lvl]));

  assign wait_we    = cmd.exec && cur.opcode == pru_pkg::OP_WAIT && lk_ok &&
                      lock_taken[lk] && !wait_full;
  assign wait_waddr = WA_W'(32'(lk) * QUEUE_DEPTH +
                            32'(fifo_tail(wait_head[lk], wait_count[lk])));
  assign wait_raddr = WA_W'(32'(lk) * QUEUE_DEPTH + 32'(wait_head[lk]));

  pru_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (LEVELS * QUEUE_DEPTH)
  ) u_ready_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (ready_waddr),
    .wdata (cmd.fetch ? wid : id),
    .re    (cmd.exec && cur.opcode == pru_pkg::OP_DEQUEUE),
    .raddr (ready_raddr),
    .rdata (ready_rdata)
  );

  pru_ram #(
    .WIDTH (WE_W),
    .DEPTH (NUM_LOCKS * QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata ({lvl, id}),
    .re    (cmd.exec && cur.opcode == pru_pkg::OP_SIGNAL),
    .raddr (wait_raddr),
    .rdata (wait_rdata)
  );

  always_comb begin
    stat.out_free   = !out_valid || out_ready;
    stat.needs_read = (cur.opcode == pru_pkg::OP_DEQUEUE && deq_hit) ||
                      (cur.opcode == pru_pkg::OP_SIGNAL && lk_ok && has_waiter);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        ready_head[i]  <= '0;
        ready_count[i] <= '0;
      end
      for (int i = 0; i < NUM_LOCKS; i++) begin
        wait_head[i]   <= '0;
        wait_count[i]  <= '0;
        lock_taken[i]  <= 1'b0;
        owner_store[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (push_we) begin
        ready_count[push_lvl] <= ready_count[push_lvl] + CNT_W'(1);
      end
      if (cmd.exec) begin
        case (cur.opcode)
          pru_pkg::OP_DEQUEUE: begin
            if (deq_hit) begin
              ready_head[deq_lvl]  <= ptr_inc(ready_head[deq_lvl]);
              ready_count[deq_lvl] <= ready_count[deq_lvl] - CNT_W'(1);
            end
          end
          pru_pkg::OP_WAIT: begin
            if (lk_ok) begin
              if (!lock_taken[lk]) begin
                lock_taken[lk]  <= 1'b1;
                owner_store[lk] <= id;
              end else if (!wait_full) begin
                wait_count[lk] <= wait_count[lk] + CNT_W'(1);
              end
            end
          end
          pru_pkg::OP_SIGNAL: begin
            if (lk_ok) begin
              if (has_waiter) begin
                wait_head[lk]  <= ptr_inc(wait_head[lk]);
                wait_count[lk] <= wait_count[lk] - CNT_W'(1);
              end else begin
                lock_taken[lk]  <= 1'b0;
                owner_store[lk] <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      // handoff: the oldest waiter now owns the mutex, which stays taken
      if (cmd.fetch && cur.opcode == pru_pkg::OP_SIGNAL) begin
        owner_store[lk] <= wid;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= in_data;
    end
    if (cmd.exec) begin
      res_task  <= '0;
      res_owner <= '0;
      case (cur.opcode)
        pru_pkg::OP_ENQUEUE: begin
          res_status <= push_ok ? pru_pkg::ST_ENQUEUED : pru_pkg::ST_READY_FULL;
        end
        pru_pkg::OP_DEQUEUE: begin
          res_status <= deq_hit ? pru_pkg::ST_DEQUEUED : pru_pkg::ST_READY_EMPTY;
        end
        pru_pkg::OP_WAIT: begin
          if (!lk_ok) begin
            res_status <= pru_pkg::ST_INVALID_LOCK;
          end else if (!lock_taken[lk]) begin
            res_status <= pru_pkg::ST_ACQUIRED;
            res_owner  <= 8'(id);
          end else begin
            res_status <= wait_full ? pru_pkg::ST_WAIT_FULL : pru_pkg::ST_BLOCKED;
            res_owner  <= 8'(owner_store[lk]);
          end
        end
        pru_pkg::OP_SIGNAL: begin
          if (!lk_ok) begin
            res_status <= pru_pkg::ST_INVALID_LOCK;
          end else begin
            res_status <= has_waiter ? pru_pkg::ST_WOKE_WAITER : pru_pkg::ST_RELEASED;
          end
        end
        default: res_status <= pru_pkg::ST_INVALID_LOCK;
      endcase
    end
    if (cmd.fetch) begin
      if (cur.opcode == pru_pkg::OP_SIGNAL) begin
        res_task  <= 8'(wid);
        res_owner <= 8'(wid);
      end else begin
        res_task <= 8'(ready_rdata);
      end
    end
    if (cmd.load_out) begin
      out_data.status     <= res_status;
      out_data.out_task   <= res_task;
      out_data.lock_owner <= res_owner;
    end
  end

endmodule
`default_nettype wire

[hdl/priority_ready_queue_mutex_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_mutex_unit
// Per-level ready FIFOs and binary mutexes with wait FIFOs.
// ----------------------------------------------------------------------------
// One command is processed per transaction and each gives one result. The
// result is loaded after the execute step; a dequeue that finds a task and a
// signal that wakes a waiter also pass a fetch step, since the FIFO entry
// comes out of a memory with a registered read port. The next command is
// taken in the cycle after the result is loaded, even while that result is
// still waiting on out_ready, so a new command is not accepted before the
// previous one has loaded its result. A new result waits for the previous
// one to be taken before it is loaded. The sequencer is the limit: one
// command is in flight at a time. The FIFO memories need no clearing after
// reset.
module priority_ready_queue_mutex_unit #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LOCKS   = 3,
  parameter int ID_BITS     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pru_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pru_pkg::out_item_t      out_data
);

  pru_pkg::ctl_cmd_t cmd;
  pru_pkg::dp_stat_t stat;

  pru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pru_datapath #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_LOCKS   (NUM_LOCKS),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority ready queue and mutex unit. Commands go
// in over valid/ready with random gaps, results come out against a random
// out_ready stall. A scoreboard keeps its own copy of the ready FIFOs, the
// mutexes and their wait FIFOs, and checks every result field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_LEVELS    = 4;
  localparam int FIFO_DEPTH  = 16;
  localparam int N_LOCKS     = 3;
  localparam int ITEM_TARGET = 750;
  localparam int CYCLE_LIMIT = 500000;

  // Predicts each result from the commands accepted so far and checks the
  // results that come out against those predictions, oldest first.
  class sched_scoreboard;
    logic [7:0]          ready_task [N_LEVELS][FIFO_DEPTH];
    int                  ready_rd   [N_LEVELS];
    int                  ready_cnt  [N_LEVELS];
    logic [7:0]          wait_task  [N_LOCKS][FIFO_DEPTH];
    int                  wait_lvl   [N_LOCKS][FIFO_DEPTH];
    int                  wait_rd    [N_LOCKS];
    int                  wait_cnt   [N_LOCKS];
    bit                  lock_held  [N_LOCKS];
    logic [7:0]          lock_holder[N_LOCKS];
    pru_pkg::out_item_t  expected_results[$];
    int                  errors;

    function new();
      foreach (lock_holder[i]) lock_holder[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit ready_push(logic [7:0] id, int lvl);
      if (ready_cnt[lvl] >= FIFO_DEPTH) return 1'b0;
      ready_task[lvl][(ready_rd[lvl] + ready_cnt[lvl]) % FIFO_DEPTH] = id;
      ready_cnt[lvl]++;
      return 1'b1;
    endfunction

    function void note_command(pru_pkg::in_item_t cmd);
      pru_pkg::out_item_t res;
      int                 lvl;
      int                 lk;
      int                 slot;
      int                 wake_lvl;
      logic [7:0]         wake_id;
      bit                 found;
      res   = '0;
      found = 1'b0;
      lvl   = cmd.prio_level;
      if (lvl >= N_LEVELS) lvl = N_LEVELS - 1;
      lk = cmd.lock_id;
      if (cmd.opcode == pru_pkg::OP_ENQUEUE) begin
        res.status = ready_push(cmd.task_id, lvl) ? pru_pkg::ST_ENQUEUED
                                                  : pru_pkg::ST_READY_FULL;
      end else if (cmd.opcode == pru_pkg::OP_DEQUEUE) begin
        res.status = pru_pkg::ST_READY_EMPTY;
        for (int i = 0; i < N_LEVELS && !found; i++) begin
          if (ready_cnt[i] != 0) begin
            res.out_task = ready_task[i][ready_rd[i]];
            ready_rd[i]  = (ready_rd[i] + 1) % FIFO_DEPTH;
            ready_cnt[i]--;
            res.status = pru_pkg::ST_DEQUEUED;
            found      = 1'b1;
          end
        end
      end else if (lk >= N_LOCKS) begin
        res.status = pru_pkg::ST_INVALID_LOCK;
      end else if (cmd.opcode == pru_pkg::OP_WAIT) begin
        if (!lock_held[lk]) begin
          lock_held[lk]   = 1'b1;
          lock_holder[lk] = cmd.task_id;
          res.status      = pru_pkg::ST_ACQUIRED;
        end else if (wait_cnt[lk] >= FIFO_DEPTH) begin
          res.status = pru_pkg::ST_WAIT_FULL;
        end else begin
          // the owner itself may queue up behind its own lock
          slot                = (wait_rd[lk] + wait_cnt[lk]) % FIFO_DEPTH;
          wait_task[lk][slot] = cmd.task_id;
          wait_lvl[lk][slot]  = lvl;
          wait_cnt[lk]++;
          res.status = pru_pkg::ST_BLOCKED;
        end
        res.lock_owner = lock_holder[lk];
      end else begin
        if (wait_cnt[lk] != 0) begin
          wake_id     = wait_task[lk][wait_rd[lk]];
          wake_lvl    = wait_lvl[lk][wait_rd[lk]];
          wait_rd[lk] = (wait_rd[lk] + 1) % FIFO_DEPTH;
          wait_cnt[lk]--;
          lock_held[lk]   = 1'b1;
          lock_holder[lk] = wake_id;
          // handoff happens even when the waiter's ready FIFO is full
          void'(ready_push(wake_id, wake_lvl));
          res.out_task = wake_id;
          res.status   = pru_pkg::ST_WOKE_WAITER;
        end else begin
          lock_held[lk]   = 1'b0;
          lock_holder[lk] = '0;
          res.status      = pru_pkg::ST_RELEASED;
        end
        res.lock_owner = lock_holder[lk];
      end
      expected_results.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(pru_pkg::out_item_t got);
      pru_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %h with no command outstanding", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.out_task !== want.out_task)
        report($sformatf("out_task got %h want %h", got.out_task, want.out_task));
      if (got.lock_owner !== want.lock_owner)
        report($sformatf("lock_owner got %h want %h", got.lock_owner,
                         want.lock_owner));
    endtask
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pru_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pru_pkg::out_item_t out_data;

  sched_scoreboard board;
  int  sent        = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  no_idle     = 1'b0;

  priority_ready_queue_mutex_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pru_pkg::in_item_t make_cmd(logic [1:0] op, logic [7:0] id,
                                                 logic [1:0] prio, logic [1:0] lock);
    pru_pkg::in_item_t cmd;
    cmd.opcode     = op;
    cmd.task_id    = id;
    cmd.prio_level = prio;
    cmd.lock_id    = lock;
    return cmd;
  endfunction

  function automatic pru_pkg::in_item_t random_cmd();
    int         r;
    logic [1:0] op;
    logic [1:0] lock;
    r = $urandom_range(99);
    if (r < 30)      op = pru_pkg::OP_ENQUEUE;
    else if (r < 55) op = pru_pkg::OP_DEQUEUE;
    else if (r < 80) op = pru_pkg::OP_WAIT;
    else             op = pru_pkg::OP_SIGNAL;
    lock = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    return make_cmd(op, 8'($urandom_range(255)), 2'($urandom_range(3)), lock);
  endfunction

  task automatic send_command(pru_pkg::in_item_t cmd);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    board.note_command(cmd);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // one burst of related commands so FIFOs fill up and drain again
  task automatic run_burst();
    int kind;
    int len;
    int lvl;
    int lk;
    kind    = $urandom_range(9);
    len     = $urandom_range(8, 22);
    lvl     = $urandom_range(3);
    lk      = $urandom_range(2);
    no_idle = ($urandom_range(4) == 0);
    for (int n = 0; n < len; n++) begin
      case (kind)
        0, 1, 2, 3: send_command(random_cmd());
        4:          send_command(make_cmd(pru_pkg::OP_ENQUEUE, 8'($urandom_range(255)),
                                          2'(lvl), 2'($urandom_range(3))));
        5, 6:       send_command(make_cmd(pru_pkg::OP_WAIT, 8'($urandom_range(255)),
                                          2'($urandom_range(3)), 2'(lk)));
        7:          send_command(make_cmd(pru_pkg::OP_DEQUEUE, 8'($urandom_range(255)),
                                          2'($urandom_range(3)),
                                          2'($urandom_range(3))));
        default:    send_command(make_cmd(pru_pkg::OP_SIGNAL, 8'($urandom_range(255)),
                                          2'($urandom_range(3)), 2'(lk)));
      endcase
    end
  endtask

  // receiver side backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    pru_pkg::in_item_t directed[$];
    bit                drained;
    board   = new();
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0),    // nothing ready yet
      make_cmd(pru_pkg::OP_ENQUEUE, 8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_ENQUEUE, 8'hFF, 2'd3, 2'd3),
      make_cmd(pru_pkg::OP_ENQUEUE, 8'hAA, 2'd1, 2'd1),
      make_cmd(pru_pkg::OP_ENQUEUE, 8'h55, 2'd2, 2'd2),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'hFF, 2'd3, 2'd3),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_WAIT,    8'hFF, 2'd0, 2'd0),    // free lock acquired
      make_cmd(pru_pkg::OP_WAIT,    8'h12, 2'd3, 2'd0),
      make_cmd(pru_pkg::OP_WAIT,    8'hFF, 2'd1, 2'd0),    // owner waits on itself
      make_cmd(pru_pkg::OP_SIGNAL,  8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_SIGNAL,  8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_SIGNAL,  8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_SIGNAL,  8'hFF, 2'd3, 2'd0),    // already free, stays free
      make_cmd(pru_pkg::OP_WAIT,    8'h3C, 2'd2, 2'd3),    // lock index out of range
      make_cmd(pru_pkg::OP_SIGNAL,  8'hC3, 2'd1, 2'd3),
      make_cmd(pru_pkg::OP_WAIT,    8'h00, 2'd2, 2'd2),
      make_cmd(pru_pkg::OP_WAIT,    8'h81, 2'd0, 2'd1),
      make_cmd(pru_pkg::OP_SIGNAL,  8'h00, 2'd0, 2'd2),
      make_cmd(pru_pkg::OP_SIGNAL,  8'h00, 2'd0, 2'd1),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0),
      make_cmd(pru_pkg::OP_DEQUEUE, 8'h00, 2'd0, 2'd0)
    };
    foreach (directed[i]) send_command(directed[i]);

    while (sent < ITEM_TARGET) begin
      run_burst();
      if (!drained && sent >= ITEM_TARGET / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pru_pkg.sv
hdl/pru_ram.sv
hdl/pru_ctrl.sv
hdl/pru_datapath.sv
hdl/priority_ready_queue_mutex_unit.sv
tb/testbench.sv
